// ===== rtl/lerb_pkg.sv =====
package lerb_pkg;

	localparam int DEF_BUFFER_DEPTH = 256;

	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] KEY_NEWLINE   = 8'd10;

	typedef enum logic [1:0] {
		CMD_KEY   = 2'd0,
		CMD_LEFT  = 2'd1,
		CMD_RIGHT = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_PRINT = 2'd1,
		ACT_LEFT  = 2'd2,
		ACT_RIGHT = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		OP_NOP     = 3'd0,
		OP_INSERT  = 3'd1,
		OP_BKSP    = 3'd2,
		OP_NEWLINE = 3'd3,
		OP_DROP    = 3'd4,
		OP_LEFT    = 3'd5,
		OP_RIGHT   = 3'd6,
		OP_READ    = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SHIFT = 2'd1,
		ST_DONE  = 2'd2
	} st_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] key_char;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic       read_valid;
		act_t       echo_action;
		logic [7:0] echo_char;
		logic       dropped;
	} out_beat_t;

endpackage

// ===== rtl/lerb_store.sv =====
module lerb_store import lerb_pkg::*; #(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
	parameter int PTR_W        = $clog2(BUFFER_DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [PTR_W-1:0] rd_addr,
	output logic [7:0]       rd_data,
	input  logic             wr_en,
	input  logic [PTR_W-1:0] wr_addr,
	input  logic [7:0]       wr_data
);

	logic [7:0] mem [BUFFER_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/lerb_ctrl.sv =====
module lerb_ctrl import lerb_pkg::*; #(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
	parameter int PTR_W        = $clog2(BUFFER_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_beat_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_beat_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	output logic             rd_en,
	output logic [PTR_W-1:0] rd_addr,
	input  logic [7:0]       rd_data,
	output logic             wr_en,
	output logic [PTR_W-1:0] wr_addr,
	output logic [7:0]       wr_data
);

	localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(BUFFER_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_DEPTH);
	localparam logic [FILL_W-1:0] FILL_KEY_MAX = FILL_W'(BUFFER_DEPTH - 1);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST) ? '0 : PTR_W'(p + PTR_W'(1));
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? LAST : PTR_W'(p - PTR_W'(1));
	endfunction

	st_t               state_q, state_d;
	op_t               op_q, op_d;
	logic [7:0]        key_q, key_d;
	logic [PTR_W-1:0]  it_q, it_d;
	logic              pend_q, pend_d;
	logic [PTR_W-1:0]  pend_addr_q, pend_addr_d;
	logic [PTR_W-1:0]  start_q, start_d;
	logic [PTR_W-1:0]  end_q, end_d;
	logic [PTR_W-1:0]  cursor_q, cursor_d;
	logic [PTR_W-1:0]  rdptr_q, rdptr_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              out_valid_q, out_valid_d;
	out_beat_t         out_q, out_d;
	logic              echo_q;
	logic              out_free;
	logic              open_dir;
	logic              stop;
	out_beat_t         beat;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign wr_en   = pend_q || (state_q == ST_DONE && (op_q == OP_INSERT || op_q == OP_NEWLINE));
	assign wr_addr = pend_q ? pend_addr_q : ((op_q == OP_INSERT) ? cursor_q : end_q);
	assign wr_data = pend_q ? rd_data : key_q;

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		key_d       = key_q;
		it_d        = it_q;
		pend_d      = 1'b0;
		pend_addr_d = pend_addr_q;
		start_d     = start_q;
		end_d       = end_q;
		cursor_d    = cursor_q;
		rdptr_d     = rdptr_q;
		fill_d      = fill_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && out_stall;
		rd_en       = 1'b0;
		rd_addr     = rdptr_q;
		open_dir    = (op_q == OP_INSERT);
		stop        = open_dir ? (it_q == cursor_q) : (it_q == end_q);
		beat        = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					key_d   = in_data.key_char;
					state_d = ST_DONE;
					op_d    = OP_NOP;
					unique case (in_data.command)
						CMD_KEY: begin
							if (in_data.key_char == KEY_BACKSPACE) begin
								if (cursor_q != start_q) begin
									op_d    = OP_BKSP;
									it_d    = cursor_q;
									state_d = ST_SHIFT;
								end
							end else if (in_data.key_char == KEY_NEWLINE) begin
								op_d = (fill_q != FILL_FULL) ? OP_NEWLINE : OP_DROP;
							end else if (fill_q < FILL_KEY_MAX) begin
								op_d    = OP_INSERT;
								it_d    = end_q;
								state_d = ST_SHIFT;
							end else begin
								op_d = OP_DROP;
							end
						end
						CMD_LEFT: begin
							if (cursor_q != start_q) begin
								op_d = OP_LEFT;
							end
						end
						CMD_RIGHT: begin
							if (cursor_q != end_q) begin
								op_d = OP_RIGHT;
							end
						end
						CMD_READ: begin
							if (rdptr_q != start_q) begin
								op_d    = OP_READ;
								rd_en   = 1'b1;
								rd_addr = rdptr_q;
							end
						end
						default: begin
							op_d = OP_NOP;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				if (stop) begin
					state_d = ST_DONE;
				end else begin
					rd_en  = 1'b1;
					pend_d = 1'b1;
					if (open_dir) begin
						rd_addr     = ptr_dec(it_q);
						pend_addr_d = it_q;
						it_d        = ptr_dec(it_q);
					end else begin
						rd_addr     = it_q;
						pend_addr_d = ptr_dec(it_q);
						it_d        = ptr_inc(it_q);
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					unique case (op_q)
						OP_INSERT: begin
							cursor_d    = ptr_inc(cursor_q);
							end_d       = ptr_inc(end_q);
							fill_d      = FILL_W'(fill_q + FILL_W'(1));
							beat.echo_action = ACT_PRINT;
							beat.echo_char   = key_q;
						end
						OP_BKSP: begin
							cursor_d    = ptr_dec(cursor_q);
							end_d       = ptr_dec(end_q);
							fill_d      = FILL_W'(fill_q - FILL_W'(1));
							beat.echo_action = ACT_PRINT;
							beat.echo_char   = key_q;
						end
						OP_NEWLINE: begin
							end_d       = ptr_inc(end_q);
							start_d     = ptr_inc(end_q);
							cursor_d    = ptr_inc(end_q);
							fill_d      = FILL_W'(fill_q + FILL_W'(1));
							beat.echo_action = ACT_PRINT;
							beat.echo_char   = key_q;
						end
						OP_DROP: begin
							beat.dropped     = 1'b1;
							beat.echo_action = ACT_PRINT;
							beat.echo_char   = key_q;
						end
						OP_LEFT: begin
							cursor_d         = ptr_dec(cursor_q);
							beat.echo_action = ACT_LEFT;
						end
						OP_RIGHT: begin
							cursor_d         = ptr_inc(cursor_q);
							beat.echo_action = ACT_RIGHT;
						end
						OP_READ: begin
							rdptr_d         = ptr_inc(rdptr_q);
							fill_d          = FILL_W'(fill_q - FILL_W'(1));
							beat.read_char  = rd_data;
							beat.read_valid = 1'b1;
						end
						OP_NOP: begin
							beat = '0;
						end
						default: begin
							beat = '0;
						end
					endcase
					if (!echo_q) begin
						beat.echo_action = ACT_NONE;
						beat.echo_char   = '0;
					end
					out_d       = beat;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_NOP;
			pend_q      <= 1'b0;
			start_q     <= '0;
			end_q       <= '0;
			cursor_q    <= '0;
			rdptr_q     <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			echo_q      <= 1'b1;
		end else begin
			state_q     <= state_d;
			op_q        <= op_d;
			pend_q      <= pend_d;
			start_q     <= start_d;
			end_q       <= end_d;
			cursor_q    <= cursor_d;
			rdptr_q     <= rdptr_d;
			fill_q      <= fill_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				echo_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q       <= key_d;
		it_q        <= it_d;
		pend_addr_q <= pend_addr_d;
		out_q       <= out_d;
	end

endmodule

// ===== rtl/line_edit_ring_buffer.sv =====
// Line-editing keyboard buffer with a ring store of BUFFER_DEPTH characters.
// Input beats carry a command (key, cursor left, cursor right, read) and a
// key code; each accepted beat yields exactly one output beat carrying the
// popped character, its valid flag, an echo action with its character and a
// dropped flag. echo_enable is written through cfg_we/cfg_wdata; the user must
// write it only while idle (not enforced by the block). Cursor moves, reads,
// newline and dropped keys go from the idle state to the done state, which
// registers the output beat. Insert and backspace first move the tail of the
// line one entry per cycle through the single store port pair before the done state.
// in_stall is high while a beat is being worked on; one beat at a time.
// A finished output beat waits in the output register while out_stall is
// high; the next input beat is still accepted and runs until its own result
// needs the output register, where it holds.
// Reset clears all pointers and the fill count, empties the output register
// and sets echo_enable to 1. Store contents are not cleared; no command reads
// an entry before it has been written.
module line_edit_ring_buffer import lerb_pkg::*; #(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	localparam int PTR_W = $clog2(BUFFER_DEPTH);

	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic [7:0]       rd_data;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic [7:0]       wr_data;

	lerb_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.PTR_W(PTR_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	lerb_store #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.PTR_W(PTR_W)
	) u_store (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule
